/* rtl/core/twrp_pkg.sv */
`default_nettype none
package twrp_pkg;

	localparam int ADDR_W = 3;

	// register word index, taken from paddr[2]
	localparam logic REG_FRONT = 1'b0;
	localparam logic REG_BACK  = 1'b1;

	localparam logic [1:0] GRP_FRONT  = 2'd0;
	localparam logic [1:0] GRP_MIDDLE = 2'd1;
	localparam logic [1:0] GRP_BACK   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_DEC,
		ST_FWR,
		ST_BW1,
		ST_BW2,
		ST_ERD,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic [1:0]  res;
		logic [15:0] score;
		logic [7:0]  tag;
	} word_t;

	// residue modulo 3: 4**k is 1 mod 3, so fold base-4 digits
	function automatic logic [1:0] mod3(input logic [15:0] s);
		logic [4:0] sum;
		logic [2:0] t;
		logic [2:0] u;
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + {3'b000, s[2*i +: 2]};
		end
		t = {1'b0, sum[1:0]} + {1'b0, sum[3:2]} + {2'b00, sum[4]};
		u = {1'b0, t[1:0]} + {2'b00, t[2]};
		if (u >= 3'd3) begin
			u = u - 3'd3;
		end
		return u[1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/three_way_residue_partition.sv */
`default_nettype none
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pwrite  paddr, pwdata -> prdata (pready tied high)
// records   in         in_valid/in_ready    score, record_tag, last_item
// results   out        out_valid/out_ready  out_score, out_tag, group, front_count,
//                                           back_start, last_result, overflow
//
// Records load one per cycle while idle; the record marked last starts the partition.
// Each scan step reads the single-write, dual-read store, then keeps a middle record
// or swaps a front or back record to its boundary. Each result is read from the store,
// then presented and held while out_ready is low. in_ready is low from the last record
// until the final result is taken. Reset clears the control state only; the store
// needs no clearing pass.
module three_way_residue_partition #(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [twrp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [15:0]                  score,
	input  wire logic [7:0]                   record_tag,
	input  wire logic                         last_item,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [15:0]                  out_score,
	output logic      [7:0]                   out_tag,
	output logic      [1:0]                   group,
	output logic      [6:0]                   front_count,
	output logic      [6:0]                   back_start,
	output logic                              last_result,
	output logic                              overflow
);
	import twrp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, front_q, scan_q, back_q, pos_q;
	logic            ovf_q;
	logic [1:0]      front_res_q, back_res_q;

	word_t           mem_q [DEPTH];
	word_t           rd_a_q, rd_b_q;

	logic            we, re_a, re_b;
	logic [AW-1:0]   waddr, ra, rb;
	word_t           wdata;

	logic            in_acc, out_acc, cfg_wr, has_room, scan_lt_back;
	logic            is_front, is_back, emit_last;
	logic [CW-1:0]   back_m1, pos_p1;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite;
	assign in_acc       = in_valid && in_ready;
	assign out_acc      = out_valid && out_ready;
	assign has_room     = count_q < CW'(DEPTH);
	assign scan_lt_back = scan_q < back_q;
	assign is_front     = rd_a_q.res == front_res_q;
	assign is_back      = !is_front && (rd_a_q.res == back_res_q);
	assign back_m1      = back_q - 1'b1;
	assign pos_p1       = pos_q + 1'b1;
	assign emit_last    = pos_p1 == count_q;

	always_comb begin
		case (paddr[2])
			REG_FRONT: prdata = {30'd0, front_res_q};
			REG_BACK:  prdata = {30'd0, back_res_q};
			default:   prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && last_item) state_d = ST_RD;
			ST_RD:   state_d = scan_lt_back ? ST_DEC : ST_ERD;
			ST_DEC: begin
				if (is_front)      state_d = ST_FWR;
				else if (is_back)  state_d = ST_BW1;
				else               state_d = ST_RD;
			end
			ST_FWR:  state_d = ST_RD;
			ST_BW1:  state_d = ST_BW2;
			ST_BW2:  state_d = ST_RD;
			ST_ERD:  state_d = ST_EOUT;
			ST_EOUT: if (out_ready) state_d = emit_last ? ST_IDLE : ST_ERD;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and store port controls
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		we        = 1'b0;
		waddr     = count_q[AW-1:0];
		wdata     = rd_a_q;
		re_a      = 1'b0;
		ra        = scan_q[AW-1:0];
		re_b      = 1'b0;
		rb        = front_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				we       = in_valid && has_room;
				wdata    = '{res: mod3(score), score: score, tag: record_tag};
			end
			ST_RD: begin
				re_a = 1'b1;
				re_b = 1'b1;
			end
			ST_DEC: begin
				if (is_front) begin
					we    = 1'b1;
					waddr = front_q[AW-1:0];
				end else if (is_back) begin
					// fetch the record just inside the back boundary
					re_b = 1'b1;
					rb   = back_m1[AW-1:0];
				end
			end
			ST_FWR: begin
				we    = 1'b1;
				waddr = scan_q[AW-1:0];
				wdata = rd_b_q;
			end
			ST_BW1: begin
				we    = 1'b1;
				waddr = back_q[AW-1:0];
			end
			ST_BW2: begin
				we    = 1'b1;
				waddr = scan_q[AW-1:0];
				wdata = rd_b_q;
			end
			ST_ERD: begin
				re_a = 1'b1;
				ra   = pos_q[AW-1:0];
			end
			ST_EOUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign out_score   = rd_a_q.score;
	assign out_tag     = rd_a_q.tag;
	assign front_count = 7'(front_q);
	assign back_start  = 7'(back_q);
	assign last_result = emit_last;
	assign overflow    = ovf_q;

	always_comb begin
		if (pos_q < front_q)      group = GRP_FRONT;
		else if (pos_q >= back_q) group = GRP_BACK;
		else                      group = GRP_MIDDLE;
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re_a) rd_a_q <= mem_q[ra];
		if (re_b) rd_b_q <= mem_q[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			front_res_q <= 2'd0;
			back_res_q  <= 2'd1;
			front_q     <= '0;
			scan_q      <= '0;
			back_q      <= '0;
			pos_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[2])
					REG_FRONT: front_res_q <= pwdata[1:0];
					REG_BACK:  back_res_q  <= pwdata[1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (has_room) count_q <= count_q + 1'b1;
						else          ovf_q   <= 1'b1;
						if (last_item) begin
							front_q <= '0;
							scan_q  <= '0;
							back_q  <= has_room ? count_q + 1'b1 : count_q;
						end
					end
				end
				ST_RD: if (!scan_lt_back) pos_q <= '0;
				ST_DEC: begin
					if (is_front)     front_q <= front_q + 1'b1;
					else if (is_back) back_q  <= back_m1;
					else              scan_q  <= scan_q + 1'b1;
				end
				ST_FWR: scan_q <= scan_q + 1'b1;
				ST_EOUT: begin
					if (out_acc) begin
						if (emit_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							pos_q <= pos_p1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/twrp_checker.sv */
`default_nettype none
module twrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_item,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_score,
	input wire logic [7:0]  out_tag,
	input wire logic [1:0]  group,
	input wire logic [6:0]  front_count,
	input wire logic [6:0]  back_start,
	input wire logic        last_result
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_tag))
		else $error("result changed while stalled");

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready to load while emitting");

	// the last record closes the input; a_reopen checks that the final result opens it again
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_item |=> !in_ready)
		else $error("input still open after last record");

	// the final result reopens the input
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> in_ready && !out_valid)
		else $error("input not reopened after final result");

	// boundaries are ordered and the group is a real class
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> front_count <= back_start && group != 2'd3)
		else $error("inconsistent partition boundaries");

endmodule

bind three_way_residue_partition twrp_checker u_twrp_checker (.*);
`default_nettype wire

/* dv/partition_checker.sv */
`timescale 1ns / 1ps
module partition_checker #(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [twrp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	input  wire logic                         pready,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [15:0]                  score,
	input  wire logic [7:0]                   record_tag,
	input  wire logic                         last_item,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [15:0]                  out_score,
	input  wire logic [7:0]                   out_tag,
	input  wire logic [1:0]                   group,
	input  wire logic [6:0]                   front_count,
	input  wire logic [6:0]                   back_start,
	input  wire logic                         last_result,
	input  wire logic                         overflow,
	output int                                failures,
	output int                                pending
);
	import twrp_pkg::*;

	typedef struct {
		logic [15:0] score;
		logic [7:0]  tag;
		logic [1:0]  grp;
		logic [6:0]  front_count;
		logic [6:0]  back_start;
		logic        last;
		logic        dropped;
	} placement_t;

	placement_t  expected_placements[$];
	logic [15:0] held_score[DEPTH];
	logic [7:0]  held_tag[DEPTH];
	int          held_count;
	logic        dropped;
	logic [1:0]  front_res;
	logic [1:0]  back_res;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		failures++;
	endtask

	task automatic swap_held(input int a, input int b);
		logic [15:0] s;
		logic [7:0]  t;
		s = held_score[a];
		t = held_tag[a];
		held_score[a] = held_score[b];
		held_tag[a] = held_tag[b];
		held_score[b] = s;
		held_tag[b] = t;
	endtask

	// single-scan three-way split, then queue every held record in final order
	task automatic partition_held;
		int         front_n;
		int         scan;
		int         back_n;
		logic [1:0] r;
		placement_t p;
		front_n = 0;
		scan = 0;
		back_n = held_count;
		while (scan < back_n) begin
			r = 2'(held_score[scan] % 3);
			if (r == front_res) begin
				swap_held(front_n, scan);
				front_n++;
				scan++;
			end else if (r == back_res) begin
				// re-examine whatever lands at the scan position
				back_n--;
				swap_held(back_n, scan);
			end else begin
				scan++;
			end
		end
		for (int i = 0; i < held_count; i++) begin
			p.score = held_score[i];
			p.tag = held_tag[i];
			p.grp = (i < front_n) ? GRP_FRONT : ((i >= back_n) ? GRP_BACK : GRP_MIDDLE);
			p.front_count = front_n[6:0];
			p.back_start = back_n[6:0];
			p.last = (i + 1 == held_count);
			p.dropped = dropped;
			expected_placements.push_back(p);
		end
		held_count = 0;
		dropped = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			held_count = 0;
			dropped = 1'b0;
			front_res = 2'd0;
			back_res = 2'd1;
			expected_placements.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_FRONT, 2'b00}) begin
					front_res = pwdata[1:0];
				end else if (paddr == {REG_BACK, 2'b00}) begin
					back_res = pwdata[1:0];
				end
			end
			if (out_valid && out_ready) begin
				if (expected_placements.size() == 0) begin
					report_mismatch($sformatf("result with none expected: score %0d tag %0d",
						out_score, out_tag));
				end else begin
					want = expected_placements.pop_front();
					if (out_score !== want.score)
						report_mismatch($sformatf("out_score got %0d want %0d",
							out_score, want.score));
					if (out_tag !== want.tag)
						report_mismatch($sformatf("out_tag got %0d want %0d", out_tag, want.tag));
					if (group !== want.grp)
						report_mismatch($sformatf("group got %0d want %0d", group, want.grp));
					if (front_count !== want.front_count)
						report_mismatch($sformatf("front_count got %0d want %0d",
							front_count, want.front_count));
					if (back_start !== want.back_start)
						report_mismatch($sformatf("back_start got %0d want %0d",
							back_start, want.back_start));
					if (last_result !== want.last)
						report_mismatch($sformatf("last_result got %0d want %0d",
							last_result, want.last));
					if (overflow !== want.dropped)
						report_mismatch($sformatf("overflow got %0d want %0d",
							overflow, want.dropped));
				end
			end
			if (in_valid && in_ready) begin
				if (held_count < DEPTH) begin
					held_score[held_count] = score;
					held_tag[held_count] = record_tag;
					held_count++;
				end else begin
					dropped = 1'b1;
				end
				if (last_item) begin
					partition_held();
				end
			end
			pending = expected_placements.size();
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import twrp_pkg::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 12;
	localparam int HOLD_OFF    = 300;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic [15:0]         score;
	logic [7:0]          record_tag;
	logic                last_item;
	logic                out_valid;
	logic                out_ready;
	logic [15:0]         out_score;
	logic [7:0]          out_tag;
	logic [1:0]          group;
	logic [6:0]          front_count;
	logic [6:0]          back_start;
	logic                last_result;
	logic                overflow;
	int                  failures;
	int                  pending;
	int                  cycles = 0;
	bit                  quiet = 1'b0;
	bit                  hold_now = 1'b0;

	three_way_residue_partition #(.DEPTH(DEPTH)) dut (.*);

	partition_checker #(.DEPTH(DEPTH)) u_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_record(input logic [15:0] s, input logic [7:0] t, input logic l);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		score <= s;
		record_tag <= t;
		last_item <= l;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) begin
			send_record(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
				i == n - 1);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// upper bits are don't-care for a 2-bit register
		pwdata <= ($urandom & 32'hFFFF_FFFC) | {30'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// hold the sender until every queued result has come back, then let the block settle
	task automatic wait_for_drain;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : receiver
		int gap;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 3);
			if (hold_now) begin
				hold_now = 1'b0;
				gap = HOLD_OFF;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		logic [1:0] front_pick[4];
		logic [1:0] back_pick[4];
		int         sent;
		int         n;
		front_pick = '{2'd0, 2'd3, 2'd2, 2'd1};
		back_pick  = '{2'd2, 2'd2, 2'd1, 2'd3};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		score <= '0;
		record_tag <= '0;
		last_item <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset residues: zero to the front, one to the back
		write_reg(REG_FRONT, 2'd0);
		write_reg(REG_BACK, 2'd1);
		send_record(16'd0, 8'd0, 1'b1);
		send_record(16'hFFFF, 8'hFF, 1'b0);
		send_record(16'd2, 8'd1, 1'b0);
		send_record(16'd1, 8'd2, 1'b0);
		send_record(16'hFFFE, 8'h80, 1'b0);
		send_record(16'hFFFD, 8'h7F, 1'b0);
		send_record(16'd3, 8'd5, 1'b1);
		// every record goes to the back
		send_record(16'd4, 8'd10, 1'b0);
		send_record(16'd7, 8'd11, 1'b0);
		send_record(16'd10, 8'd12, 1'b1);
		wait_for_drain();
		write_reg(REG_FRONT, 2'd2);
		write_reg(REG_BACK, 2'd0);
		send_set(5);
		wait_for_drain();
		// equal residues: front wins, back group empty
		write_reg(REG_FRONT, 2'd1);
		write_reg(REG_BACK, 2'd1);
		send_set(4);
		wait_for_drain();
		// neither residue can match
		write_reg(REG_FRONT, 2'd3);
		write_reg(REG_BACK, 2'd3);
		send_set(3);

		for (int phase = 0; phase < 6; phase++) begin
			wait_for_drain();
			if (phase < 4) begin
				write_reg(REG_FRONT, front_pick[phase]);
				write_reg(REG_BACK, back_pick[phase]);
			end else begin
				write_reg(REG_FRONT, 2'($urandom_range(0, 3)));
				write_reg(REG_BACK, 2'($urandom_range(0, 3)));
			end
			quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
			// exactly full, then two past full with the last two records dropped
			if (phase == 1) send_set(DEPTH);
			if (phase == 3) send_set(DEPTH + 2);
			if (phase == 4) begin
				hold_now = 1'b1;
				send_set(3);
			end
			sent = 0;
			while (sent < 10) begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
				send_set(n);
				sent += n;
				if ($urandom_range(0, 7) == 0) wait_for_drain();
			end
		end
		wait_for_drain();

		if (failures == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
